FILE: design/sfcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcr_pkg
// Shared types and constants of the stereo feedback comb reverb.
// ----------------------------------------------------------------------------
package sfcr_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROOM_SIZE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_LEVEL = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_LEVEL = 8'd3;

  localparam logic [CFG_W-1:0] ROOM_RESET = 16'd16384;
  localparam logic [CFG_W-1:0] DAMP_RESET = 16'd6554;
  localparam logic [CFG_W-1:0] WET_RESET  = 16'd9830;
  localparam logic [CFG_W-1:0] DRY_RESET  = 16'd22938;

  localparam int FRAC_W   = 15;
  localparam int COEF_W   = 17;
  localparam int LEN_W    = 11;
  localparam int EXTRA_W  = 10;
  localparam int GAIN_W   = 15;

  localparam int ONE_Q15    = 32768;
  localparam int FB_BASE    = 13107;
  localparam int LEN_SPAN   = 900;
  localparam int LEN_BASE_L = 1000;
  localparam int LEN_BASE_R = 1050;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FB,
    ST_EXT,
    ST_GAIN,
    ST_DRYL,
    ST_WETL,
    ST_FBL,
    ST_DRYR,
    ST_WETR,
    ST_FBR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic en;
    logic accumulate;
  } mac_ctrl_t;

endpackage
`default_nettype wire

FILE: design/sfcr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcr_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: design/sfcr_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcr_mac
// Shared signed multiply-accumulate unit with a registered accumulator.
// ----------------------------------------------------------------------------
module sfcr_mac import sfcr_pkg::*; #(
  parameter int A_W = 17,
  localparam int ACC_W = A_W + COEF_W + 1
) (
  input  wire logic                     clk,
  input  wire mac_ctrl_t                ctrl,
  input  wire logic signed [A_W-1:0]    op_a,
  input  wire logic signed [COEF_W-1:0] op_b,
  output logic signed      [ACC_W-1:0]  acc
);

  logic signed [A_W+COEF_W-1:0] prod;
  logic signed [ACC_W-1:0]      acc_r;
  logic signed [ACC_W-1:0]      acc_nxt;

  always_comb begin
    prod    = op_a * op_b;
    acc_nxt = (ctrl.accumulate ? acc_r : '0) + ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

FILE: design/sfcr_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfcr_seq
// Step sequencer: orders the products of one sample pair on the shared unit.
// ----------------------------------------------------------------------------
module sfcr_seq import sfcr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_free,
  output state_t    state,
  output mac_ctrl_t ctrl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    ctrl.en         = 1'b1;
    ctrl.accumulate = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.en = 1'b0;
        if (in_fire) begin
          state_nxt = ST_FB;
        end
      end
      ST_FB:   state_nxt = ST_EXT;
      ST_EXT:  state_nxt = ST_GAIN;
      ST_GAIN: state_nxt = ST_DRYL;
      ST_DRYL: state_nxt = ST_WETL;
      ST_WETL: begin
        ctrl.accumulate = 1'b1;
        state_nxt       = ST_FBL;
      end
      ST_FBL:  state_nxt = ST_DRYR;
      ST_DRYR: state_nxt = ST_WETR;
      ST_WETR: begin
        ctrl.accumulate = 1'b1;
        state_nxt       = ST_FBR;
      end
      ST_FBR:  state_nxt = ST_DONE;
      ST_DONE: begin
        ctrl.en = 1'b0;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        ctrl.en   = 1'b0;
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule
`default_nettype wire

FILE: design/stereo_feedback_comb_reverb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_feedback_comb_reverb
// Stereo feedback comb reverb with one shared multiply-accumulate unit.
//
//   channel  direction  payload
//   in_      slave      tdata = sample_left, sample_right; tlast = block_last
//   out_     master     tdata = result_left, result_right; tlast = result_last
//   cfg_     slave      index = register, data = value
//
// a pair runs its nine products one after another through the single
// multiplier before its result is registered, and the next pair is taken
// only once the sequencer is back in idle
// in_tready is high only while the sequencer is idle
// reset needs no clearing pass: per-channel fill counts make unwritten delay
// entries read as zero
// a waiting result is held in the output register; the next pair runs and
// waits in its last step until that register is free
// ----------------------------------------------------------------------------
module stereo_feedback_comb_reverb import sfcr_pkg::*; #(
  parameter int DELAY_DEPTH  = 2048,
  parameter int SAMPLE_WIDTH = 16,
  localparam int DATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [DATA_W-1:0]    in_tdata,   // sample_left, sample_right, zero pad
  input  wire logic                 in_tlast,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic      [DATA_W-1:0]    out_tdata,  // result_left, result_right, zero pad
  output logic                      out_tlast,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int ADDR_W = $clog2(DELAY_DEPTH);
  localparam int A_W    = (SW > COEF_W) ? SW : COEF_W;
  localparam int ACC_W  = A_W + COEF_W + 1;

  function automatic logic signed [SW-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [SW-1:0] res;
    if (v[ACC_W-1:SW-1] == '0 || v[ACC_W-1:SW-1] == '1) begin
      res = v[SW-1:0];
    end else if (v[ACC_W-1]) begin
      res = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res = {1'b0, {(SW-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] next_pos(input logic [ADDR_W-1:0] p,
                                                 input logic [LEN_W-1:0]  len);
    logic [ADDR_W:0]   n;
    logic [ADDR_W-1:0] res;
    n = {1'b0, p} + (ADDR_W+1)'(1);
    if (n >= (ADDR_W+1)'(len) || n >= (ADDR_W+1)'(DELAY_DEPTH)) begin
      res = '0;
    end else begin
      res = n[ADDR_W-1:0];
    end
    return res;
  endfunction

  // configuration
  logic [CFG_W-1:0] room_r, damp_r, wet_r, dry_r;
  logic [CFG_W-1:0] room_c, damp_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_r <= ROOM_RESET;
      damp_r <= DAMP_RESET;
      wet_r  <= WET_RESET;
      dry_r  <= DRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROOM_SIZE: room_r <= cfg_data;
        REG_DAMPING:   damp_r <= cfg_data;
        REG_WET_LEVEL: wet_r  <= cfg_data;
        REG_DRY_LEVEL: dry_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign room_c = (room_r > CFG_W'(ONE_Q15)) ? CFG_W'(ONE_Q15) : room_r;
  assign damp_c = (damp_r > CFG_W'(ONE_Q15)) ? CFG_W'(ONE_Q15) : damp_r;

  // sequencer and shared unit
  state_t    state;
  mac_ctrl_t ctrl;
  logic      in_fire;
  logic      out_free;
  logic      finish;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid || out_tready;
  assign finish   = (state == ST_DONE) && out_free;

  sfcr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .state    (state),
    .ctrl     (ctrl)
  );

  logic signed [A_W-1:0]    op_a;
  logic signed [COEF_W-1:0] op_b;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sh;

  sfcr_mac #(.A_W(A_W)) u_mac (
    .clk  (clk),
    .ctrl (ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  assign acc_sh = acc >>> FRAC_W;

  // item registers
  logic signed [SW-1:0]      xl_r, xr_r, dl_r, dr_r, outl_r, outr_r;
  logic                      last_r;
  logic [GAIN_W-1:0]         fb_r, gain_r;
  logic [EXTRA_W-1:0]        extra_r;
  logic [ADDR_W-1:0]         posl_r, posr_r;
  logic [ADDR_W:0]           filll_r, fillr_r;
  logic [SW-1:0]             rdl, rdr;
  logic [LEN_W-1:0]          len_l, len_r;
  logic signed [SW-1:0]      wr_l, wr_r;
  logic signed [SW-1:0]      res_r_c;

  assign len_l = LEN_W'(LEN_BASE_L) + LEN_W'(extra_r);
  assign len_r = LEN_W'(LEN_BASE_R) + LEN_W'(extra_r);

  always_comb begin
    op_a = A_W'(xl_r);
    op_b = signed'({1'b0, dry_r});
    unique case (state)
      ST_FB: begin
        op_a = A_W'(signed'({1'b0, room_c}));
        op_b = COEF_W'(FB_BASE);
      end
      ST_EXT: begin
        op_a = A_W'(signed'({1'b0, room_c}));
        op_b = COEF_W'(LEN_SPAN);
      end
      ST_GAIN: begin
        op_a = A_W'(signed'({2'b0, fb_r}));
        op_b = signed'(COEF_W'(ONE_Q15) - {1'b0, damp_c});
      end
      ST_DRYL: begin
        op_a = A_W'(xl_r);
        op_b = signed'({1'b0, dry_r});
      end
      ST_WETL: begin
        op_a = A_W'(dl_r);
        op_b = signed'({1'b0, wet_r});
      end
      ST_FBL: begin
        op_a = A_W'(dl_r);
        op_b = signed'({2'b0, gain_r});
      end
      ST_DRYR: begin
        op_a = A_W'(xr_r);
        op_b = signed'({1'b0, dry_r});
      end
      ST_WETR: begin
        op_a = A_W'(dr_r);
        op_b = signed'({1'b0, wet_r});
      end
      ST_FBR: begin
        op_a = A_W'(dr_r);
        op_b = signed'({2'b0, gain_r});
      end
      default: ;
    endcase
  end

  assign wr_l    = sat(ACC_W'(xl_r) + acc_sh);
  assign wr_r    = sat(ACC_W'(xr_r) + acc_sh);
  assign res_r_c = sat(acc_sh);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      xl_r   <= signed'(in_tdata[SW-1:0]);
      xr_r   <= signed'(in_tdata[2*SW-1:SW]);
      last_r <= in_tlast;
    end
    unique case (state)
      ST_FB: begin
        dl_r <= ({1'b0, posl_r} < filll_r) ? signed'(rdl) : '0;
        dr_r <= ({1'b0, posr_r} < fillr_r) ? signed'(rdr) : '0;
      end
      ST_EXT:  fb_r    <= GAIN_W'(FB_BASE) + acc[FRAC_W +: GAIN_W];
      ST_GAIN: extra_r <= acc[FRAC_W +: EXTRA_W];
      ST_DRYL: gain_r  <= acc[FRAC_W +: GAIN_W];
      ST_FBL:  outl_r  <= res_r_c;
      ST_FBR:  outr_r  <= res_r_c;
      default: ;
    endcase
  end

  // delay lines
  sfcr_ram #(.WIDTH(SW), .DEPTH(DELAY_DEPTH)) u_ram_l (
    .clk   (clk),
    .we    (state == ST_DRYR),
    .waddr (posl_r),
    .wdata (wr_l),
    .raddr (posl_r),
    .rdata (rdl)
  );

  sfcr_ram #(.WIDTH(SW), .DEPTH(DELAY_DEPTH)) u_ram_r (
    .clk   (clk),
    .we    (finish),
    .waddr (posr_r),
    .wdata (wr_r),
    .raddr (posr_r),
    .rdata (rdr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      posl_r  <= '0;
      posr_r  <= '0;
      filll_r <= '0;
      fillr_r <= '0;
    end else if (finish) begin
      posl_r <= next_pos(posl_r, len_l);
      posr_r <= next_pos(posr_r, len_r);
      if ({1'b0, posl_r} == filll_r) begin
        filll_r <= filll_r + (ADDR_W+1)'(1);
      end
      if ({1'b0, posr_r} == fillr_r) begin
        fillr_r <= fillr_r + (ADDR_W+1)'(1);
      end
    end
  end

  // result register
  logic              out_valid_r;
  logic              out_last_r;
  logic [DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= DATA_W'({outr_r, outl_r});
      out_last_r <= last_r;
    end
  end

  assign in_tready  = (state == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

FILE: sim/stereo_feedback_comb_reverb_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_comb_reverb_tb
// Self-checking bench for the stereo comb reverb. Stereo pairs stream in under
// random gaps while the output side stalls at random. A bench-side copy of
// both delay lines and of the four gain registers predicts every output word,
// which is checked field by field. Phases between register changes sweep the
// room and damping ends, over-unity wet and dry, shrinking the room under the
// current position, and writes to unused register indexes.
// ----------------------------------------------------------------------------
module stereo_feedback_comb_reverb_tb import sfcr_pkg::*;;

  localparam int ECHO_DEPTH     = 2048;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_DRY_LEVEL + CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } stereo_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata = '0;
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  logic [31:0]          out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  stereo_feedback_comb_reverb uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bench copy of the block state
  logic [15:0]        room_q15 = ROOM_RESET;
  logic [15:0]        damp_q15 = DAMP_RESET;
  logic [15:0]        wet_q15  = WET_RESET;
  logic [15:0]        dry_q15  = DRY_RESET;
  logic signed [15:0] left_echo  [ECHO_DEPTH];
  logic signed [15:0] right_echo [ECHO_DEPTH];
  int unsigned        left_pos = 0;
  int unsigned        right_pos = 0;

  stereo_word_t dry_pairs[$];
  stereo_word_t wet_pairs[$];
  stereo_word_t next_dry;
  stereo_word_t want;
  int unsigned  pushed_count = 0;
  int unsigned  accepted_count = 0;
  int unsigned  errors = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  send_gap = 0;
  int unsigned  recv_stall = 0;
  bit           send_calm = 1'b0;
  bit           recv_calm = 1'b0;
  bit           in_word_taken = 1'b0;
  bit           out_word_taken = 1'b0;
  bit           cfg_word_taken = 1'b0;

  function automatic logic signed [15:0] clamp16(longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  // one comb tap: read delayed value, write back with feedback, advance
  function automatic logic signed [15:0] comb_tap(bit right_side, logic signed [15:0] x,
                                                  longint gain, int unsigned len);
    int unsigned p;
    int unsigned nxt;
    longint      d;
    longint      xs;
    longint      dry_g;
    longint      wet_g;
    logic signed [15:0] y;
    p = right_side ? right_pos : left_pos;
    d = right_side ? right_echo[p] : left_echo[p];
    xs = x;
    dry_g = dry_q15;
    wet_g = wet_q15;
    y = clamp16((xs * dry_g + d * wet_g) >>> FRAC_W);
    if (right_side) right_echo[p] = clamp16(xs + ((d * gain) >>> FRAC_W));
    else left_echo[p] = clamp16(xs + ((d * gain) >>> FRAC_W));
    nxt = p + 1;
    if (nxt >= len || nxt >= ECHO_DEPTH) nxt = 0;
    if (right_side) right_pos = nxt;
    else left_pos = nxt;
    return y;
  endfunction

  task automatic reverb_pair(stereo_word_t dry);
    longint       r;
    longint       dmp;
    longint       extra;
    longint       feedback;
    longint       gain;
    stereo_word_t wet;
    r = (room_q15 > ONE_Q15) ? ONE_Q15 : room_q15;
    dmp = (damp_q15 > ONE_Q15) ? ONE_Q15 : damp_q15;
    extra = (r * LEN_SPAN) >> FRAC_W;
    feedback = FB_BASE + ((r * FB_BASE) >> FRAC_W);
    gain = (feedback * (ONE_Q15 - dmp)) >> FRAC_W;
    wet.left = comb_tap(1'b0, dry.left, gain, LEN_BASE_L + extra);
    wet.right = comb_tap(1'b1, dry.right, gain, LEN_BASE_R + extra);
    wet.last = dry.last;
    wet_pairs.push_back(wet);
  endtask

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 31)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_level(bit above_one);
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'(ONE_Q15);
      2: return 16'($urandom_range(0, ONE_Q15));
      default: return above_one ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 32767));
    endcase
  endfunction

  // input side
  always @(posedge clk) begin
    in_word_taken = rst_n && in_tvalid && in_tready;
    if (in_word_taken) begin
      reverb_pair(stereo_word_t'{in_tdata[15:0], in_tdata[31:16], in_tlast});
      accepted_count++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_word_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (dry_pairs.size() != 0) begin
        next_dry = dry_pairs.pop_front();
        in_tdata <= {next_dry.right, next_dry.left};
        in_tlast <= next_dry.last;
        in_tvalid <= 1'b1;
        send_gap <= pick_gap(send_calm);
        if ($urandom_range(0, 63) == 0) send_calm <= !send_calm;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk) begin
    if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_stall <= pick_gap(recv_calm);
      if ($urandom_range(0, 127) == 0) recv_calm <= !recv_calm;
    end
  end

  always @(posedge clk) begin
    out_word_taken = rst_n && out_tvalid && out_tready;
    if (out_word_taken) begin
      if (wet_pairs.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
        errors++;
      end else begin
        want = wet_pairs.pop_front();
        check_field("result_left", want.left, out_tdata[15:0]);
        check_field("result_right", want.right, out_tdata[31:16]);
        check_field("result_last", 16'(want.last), 16'(out_tlast));
      end
    end
  end

  // register writes
  always @(posedge clk) begin
    cfg_word_taken = rst_n && cfg_valid && cfg_ready;
    if (cfg_word_taken) begin
      case (cfg_index)
        REG_ROOM_SIZE: room_q15 = cfg_data;
        REG_DAMPING:   damp_q15 = cfg_data;
        REG_WET_LEVEL: wet_q15 = cfg_data;
        REG_DRY_LEVEL: dry_q15 = cfg_data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (in_word_taken || out_word_taken || cfg_word_taken || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_levels(logic [15:0] room, logic [15:0] damp,
                            logic [15:0] wet, logic [15:0] dry);
    write_reg(REG_ROOM_SIZE, room);
    write_reg(REG_DAMPING, damp);
    write_reg(REG_WET_LEVEL, wet);
    write_reg(REG_DRY_LEVEL, dry);
  endtask

  task automatic queue_pair(logic [15:0] l, logic [15:0] r, logic last);
    dry_pairs.push_back(stereo_word_t'{l, r, last});
    pushed_count++;
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) queue_pair(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
  endtask

  // sender holds off until every result is back, then lets the block settle
  task automatic wait_all_back();
    while (accepted_count != pushed_count || wet_pairs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    foreach (left_echo[i]) left_echo[i] = '0;
    foreach (right_echo[i]) right_echo[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, field extremes and bit patterns
    queue_pair(16'h7fff, 16'h7fff, 1'b0);
    queue_pair(16'h8000, 16'h8000, 1'b1);
    queue_pair(16'h0000, 16'h0000, 1'b0);
    queue_pair(16'hffff, 16'h0001, 1'b0);
    queue_pair(16'h0001, 16'hffff, 1'b1);
    queue_pair(16'h7fff, 16'h8000, 1'b0);
    queue_pair(16'h8000, 16'h7fff, 1'b1);
    queue_pair(16'h5555, 16'haaaa, 1'b0);
    queue_pair(16'haaaa, 16'h5555, 1'b1);
    queue_pair(16'h0100, 16'hff00, 1'b0);
    queue_pair(16'hff00, 16'h0100, 1'b0);
    queue_pair(16'h7fff, 16'h7fff, 1'b1);
    wait_all_back();

    // shortest lines, no damping, unity mix
    set_levels(16'd0, 16'd0, 16'(ONE_Q15), 16'(ONE_Q15));
    queue_random(300);
    wait_all_back();

    // longest lines, no feedback, over-unity mix
    set_levels(16'(ONE_Q15), 16'(ONE_Q15), 16'hffff, 16'hffff);
    queue_random(250);
    wait_all_back();

    // room and damping beyond one, silent mix, unused index ignored
    set_levels(16'hffff, 16'hffff, 16'd0, 16'd0);
    write_reg(REG_FIRST_UNUSED, 16'h1234);
    write_reg(8'hff, 16'hffff);
    queue_random(450);
    wait_all_back();

    // room shrinks below the current position, echoes come back
    set_levels(16'd0, 16'd0, 16'hffff, 16'd45000);
    queue_random(300);
    wait_all_back();

    repeat (5) begin
      set_levels(pick_level(1'b1), pick_level(1'b1), pick_level(1'b1), pick_level(1'b1));
      write_reg(REG_FIRST_UNUSED + 8'($urandom_range(0, 251)), 16'($urandom));
      queue_random(60);
      wait_all_back();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
